>>> sv/bmftl_pkg.sv
// bmftl_pkg: shared types and constants of the block-mapping flash translation block
// command codes, state encoding, fixed field widths and default geometry
// no dependencies
package bmftl_pkg;

  localparam int SECTOR_W      = 10;
  localparam int PAGE_ADDR_W   = 11;
  localparam int ERASE_BLK_W   = 7;
  localparam int BLOCK_TAG_W   = 7;
  localparam int SECTOR_TAG_W  = 11;
  localparam int CMD_W         = 3;
  localparam int SECTOR_MAX    = 1023;
  localparam int RECIP_SHIFT   = 20;

  localparam int DATA_BLOCKS_DEF = 64;
  localparam int BLOCK_PAGES_DEF = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ   = 3'd0,
    CMD_PROG   = 3'd1,
    CMD_MARK   = 3'd2,
    CMD_COPY   = 3'd3,
    CMD_ERASE  = 3'd4,
    CMD_NODATA = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPLIT,
    ST_EVAL,
    ST_PROG,
    ST_MERGE,
    ST_ERASE
  } state_t;

endpackage

>>> sv/bmftl_ram.sv
// bmftl_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module bmftl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/bmftl_split.sv
// bmftl_split: splits a logical sector number into logical block and page
// reciprocal multiply into a register, then one compare and subtract correction
// depends on bmftl_pkg
module bmftl_split
  import bmftl_pkg::*;
#(
  parameter int BLOCK_PAGES = BLOCK_PAGES_DEF,
  localparam int PGW   = $clog2(BLOCK_PAGES),
  localparam int BLK_W = $clog2(SECTOR_MAX / BLOCK_PAGES + 1)
) (
  input  logic                clk,
  input  logic                load,
  input  logic [SECTOR_W-1:0] lsn,
  output logic [BLK_W-1:0]    blk,
  output logic [PGW-1:0]      page
);

  localparam int RECIP  = (1 << RECIP_SHIFT) / BLOCK_PAGES;
  localparam int PROD_W = SECTOR_W + RECIP_SHIFT;

  logic [SECTOR_W-1:0] lsn_r;
  logic [PROD_W-1:0]   prod_r;
  logic [SECTOR_W-1:0] est;
  logic [SECTOR_W:0]   rem;

  always_ff @(posedge clk) begin
    if (load) begin
      lsn_r  <= lsn;
      prod_r <= PROD_W'(lsn) * PROD_W'(RECIP);
    end
  end

  // estimate is exact or one short
  always_comb begin
    est = prod_r[PROD_W-1 -: SECTOR_W];
    rem = (SECTOR_W+1)'(lsn_r) - (SECTOR_W+1)'(est * BLOCK_PAGES);
    if (32'(rem) >= BLOCK_PAGES) begin
      blk  = BLK_W'(est + 1'b1);
      page = PGW'(rem - (SECTOR_W+1)'(BLOCK_PAGES));
    end else begin
      blk  = BLK_W'(est);
      page = PGW'(rem);
    end
  end

endmodule

>>> sv/block_mapping_flash_translation_top.sv
// block_mapping_flash_translation_top: sector read/write requests to flash page commands
// keeps block map, written-page bitmaps and the spare free block; uses bmftl_pkg,
// bmftl_split and bmftl_ram
//
// After reset the block sweeps every entry of its map memory with busy high, then accepts
// one request at a time. A request passes sector split, map read and decision before its
// first command; a plain read, a program in place, a first write to page 0, an unmapped
// read or an out-of-range request gives one command, a first write to a nonzero page gives a
// marker program and a host program on consecutive cycles, and a merge gives BLOCK_PAGES
// copy/program commands and an erase, one per cycle. Commands appear in the cycle after they
// are formed, each for exactly one cycle with out_valid; the receiver must take them as they
// come. busy stays high until the final command of a request is formed, so the map memory
// read/modify/write of one request is finished before the next one reads it.
module block_mapping_flash_translation_top
  import bmftl_pkg::*;
#(
  parameter int DATA_BLOCKS = DATA_BLOCKS_DEF,
  parameter int BLOCK_PAGES = BLOCK_PAGES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_kind,
  input  logic [SECTOR_W-1:0]            in_sector_address,
  output logic                           out_valid,
  output logic [CMD_W-1:0]               out_command,
  output logic [PAGE_ADDR_W-1:0]         out_page_address,
  output logic [PAGE_ADDR_W-1:0]         out_copy_destination,
  output logic [ERASE_BLK_W-1:0]         out_erase_block_number,
  output logic signed [BLOCK_TAG_W-1:0]  out_spare_block_tag,
  output logic signed [SECTOR_TAG_W-1:0] out_spare_sector_tag,
  output logic                           out_last
);

  localparam int PGW   = $clog2(BLOCK_PAGES);
  localparam int BLK_W = $clog2(SECTOR_MAX / BLOCK_PAGES + 1);
  localparam int MIW   = $clog2(DATA_BLOCKS);
  localparam int PBW   = $clog2(DATA_BLOCKS + 1);
  localparam int ENT_W = 1 + PBW + BLOCK_PAGES;

  state_t state_r, state_nxt;

  logic                   kind_r;
  logic [SECTOR_W-1:0]    lsn_r;
  logic [BLK_W-1:0]       blk_r;
  logic [PGW-1:0]         page_r;
  logic                   range_r;
  logic [PBW-1:0]         pbn_r;
  logic [BLOCK_PAGES-1:0] bits_r;
  logic [PBW-1:0]         free_r;
  logic [PGW-1:0]         cnt_r;
  logic [MIW-1:0]         clr_r;

  logic [BLK_W-1:0]       split_blk;
  logic [PGW-1:0]         split_page;

  logic                   mem_we;
  logic [MIW-1:0]         mem_waddr;
  logic [ENT_W-1:0]       mem_wdata;
  logic                   mem_re;
  logic [MIW-1:0]         mem_raddr;
  logic [ENT_W-1:0]       mem_rdata;

  logic                   rd_vld;
  logic [PBW-1:0]         rd_pbn;
  logic [BLOCK_PAGES-1:0] rd_bits;
  logic [BLOCK_PAGES-1:0] page_bit;
  logic [PBW-1:0]         new_pbn;
  logic                   accept;
  logic                   ev_first;
  logic                   ev_inplace;
  logic                   ev_merge;
  logic                   merge_done;

  logic                   res_vld;
  cmd_t                   res_cmd;
  logic [PAGE_ADDR_W-1:0] res_pa;
  logic [PAGE_ADDR_W-1:0] res_dst;
  logic [ERASE_BLK_W-1:0] res_eb;
  logic [BLOCK_TAG_W-1:0] res_btag;
  logic [SECTOR_TAG_W-1:0] res_stag;
  logic                   res_last;

  logic                   out_valid_r;
  logic [CMD_W-1:0]       out_cmd_r;
  logic [PAGE_ADDR_W-1:0] out_pa_r;
  logic [PAGE_ADDR_W-1:0] out_dst_r;
  logic [ERASE_BLK_W-1:0] out_eb_r;
  logic [BLOCK_TAG_W-1:0] out_btag_r;
  logic [SECTOR_TAG_W-1:0] out_stag_r;
  logic                   out_last_r;

  bmftl_split #(
    .BLOCK_PAGES(BLOCK_PAGES)
  ) u_split (
    .clk (clk),
    .load(accept),
    .lsn (in_sector_address),
    .blk (split_blk),
    .page(split_page)
  );

  bmftl_ram #(
    .WIDTH(ENT_W),
    .DEPTH(DATA_BLOCKS)
  ) u_map_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign mem_re     = (state_r == ST_SPLIT);
  assign mem_raddr  = MIW'(split_blk);

  assign rd_vld     = mem_rdata[ENT_W-1];
  assign rd_pbn     = mem_rdata[ENT_W-2 -: PBW];
  assign rd_bits    = mem_rdata[BLOCK_PAGES-1:0];
  assign page_bit   = BLOCK_PAGES'(1) << page_r;
  assign new_pbn    = PBW'(DATA_BLOCKS - 1 - 32'(blk_r));

  assign ev_first   = range_r && kind_r && !rd_vld;
  assign ev_inplace = range_r && kind_r && rd_vld && !rd_bits[page_r];
  assign ev_merge   = range_r && kind_r && rd_vld && rd_bits[page_r];
  assign merge_done = (32'(cnt_r) == BLOCK_PAGES - 1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == MIW'(DATA_BLOCKS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_nxt = ST_SPLIT;
      end
      ST_SPLIT: state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (ev_first && page_r != '0) state_nxt = ST_PROG;
        else if (ev_merge) state_nxt = ST_MERGE;
        else state_nxt = ST_IDLE;
      end
      ST_PROG: state_nxt = ST_IDLE;
      ST_MERGE: begin
        if (merge_done) state_nxt = ST_ERASE;
      end
      ST_ERASE: state_nxt = ST_IDLE;
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    res_vld   = 1'b0;
    res_cmd   = CMD_NODATA;
    res_pa    = '0;
    res_dst   = '0;
    res_eb    = '0;
    res_btag  = '0;
    res_stag  = '0;
    res_last  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = MIW'(blk_r);
    mem_wdata = '0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
      end
      ST_EVAL: begin
        res_vld = 1'b1;
        if (!range_r || (!kind_r && !rd_vld)) begin
          res_cmd  = CMD_NODATA;
          res_last = 1'b1;
        end else if (!kind_r) begin
          res_cmd  = CMD_READ;
          res_pa   = PAGE_ADDR_W'(32'(rd_pbn) * BLOCK_PAGES + 32'(page_r));
          res_last = 1'b1;
        end else if (ev_first) begin
          mem_we    = 1'b1;
          mem_wdata = {1'b1, new_pbn, page_bit};
          if (page_r != '0) begin
            res_cmd  = CMD_MARK;
            res_pa   = PAGE_ADDR_W'(32'(new_pbn) * BLOCK_PAGES);
            res_btag = BLOCK_TAG_W'(blk_r);
            res_stag = '1;
          end else begin
            res_cmd  = CMD_PROG;
            res_pa   = PAGE_ADDR_W'(32'(new_pbn) * BLOCK_PAGES);
            res_btag = BLOCK_TAG_W'(blk_r);
            res_stag = SECTOR_TAG_W'(lsn_r);
            res_last = 1'b1;
          end
        end else if (ev_inplace) begin
          mem_we    = 1'b1;
          mem_wdata = {1'b1, rd_pbn, rd_bits | page_bit};
          res_cmd   = CMD_PROG;
          res_pa    = PAGE_ADDR_W'(32'(rd_pbn) * BLOCK_PAGES + 32'(page_r));
          res_btag  = (page_r == '0) ? BLOCK_TAG_W'(blk_r) : '1;
          res_stag  = SECTOR_TAG_W'(lsn_r);
          res_last  = 1'b1;
        end else begin
          res_vld = 1'b0;
        end
      end
      ST_PROG: begin
        res_vld  = 1'b1;
        res_cmd  = CMD_PROG;
        res_pa   = PAGE_ADDR_W'(32'(pbn_r) * BLOCK_PAGES + 32'(page_r));
        res_btag = (page_r == '0) ? BLOCK_TAG_W'(blk_r) : '1;
        res_stag = SECTOR_TAG_W'(lsn_r);
        res_last = 1'b1;
      end
      ST_MERGE: begin
        res_vld = 1'b1;
        if (cnt_r == page_r) begin
          res_cmd  = CMD_PROG;
          res_pa   = PAGE_ADDR_W'(32'(free_r) * BLOCK_PAGES + 32'(cnt_r));
          res_btag = (cnt_r == '0) ? BLOCK_TAG_W'(blk_r) : '1;
          res_stag = SECTOR_TAG_W'(lsn_r);
        end else begin
          res_cmd = CMD_COPY;
          res_pa  = PAGE_ADDR_W'(32'(pbn_r) * BLOCK_PAGES + 32'(cnt_r));
          res_dst = PAGE_ADDR_W'(32'(free_r) * BLOCK_PAGES + 32'(cnt_r));
        end
      end
      ST_ERASE: begin
        res_vld   = 1'b1;
        res_cmd   = CMD_ERASE;
        res_eb    = ERASE_BLK_W'(pbn_r);
        res_last  = 1'b1;
        mem_we    = 1'b1;
        mem_wdata = {1'b1, free_r, bits_r};
      end
      default: begin
        res_vld = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      free_r      <= PBW'(DATA_BLOCKS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= res_vld;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (state_r == ST_EVAL) begin
        cnt_r <= '0;
      end else if (state_r == ST_MERGE) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (state_r == ST_ERASE) begin
        free_r <= pbn_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      lsn_r  <= in_sector_address;
    end
    if (state_r == ST_SPLIT) begin
      blk_r   <= split_blk;
      page_r  <= split_page;
      range_r <= (32'(split_blk) < DATA_BLOCKS);
    end
    if (state_r == ST_EVAL) begin
      pbn_r  <= ev_first ? new_pbn : rd_pbn;
      bits_r <= rd_bits;
    end
    out_cmd_r  <= res_cmd;
    out_pa_r   <= res_pa;
    out_dst_r  <= res_dst;
    out_eb_r   <= res_eb;
    out_btag_r <= res_btag;
    out_stag_r <= res_stag;
    out_last_r <= res_last;
  end

  assign out_valid              = out_valid_r;
  assign out_command            = out_cmd_r;
  assign out_page_address       = out_pa_r;
  assign out_copy_destination   = out_dst_r;
  assign out_erase_block_number = out_eb_r;
  assign out_spare_block_tag    = $signed(out_btag_r);
  assign out_spare_sector_tag   = $signed(out_stag_r);
  assign out_last               = out_last_r;

  a_no_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) != ST_IDLE && $past(state_r) != ST_CLEAR))
    else $error("result without a transaction in progress");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("result follows the final result of a transaction");

  a_map_rw_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re && mem_waddr == mem_raddr))
    else $error("map read and write to the same entry overlap");

  a_free_swap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ERASE) |=> (free_r == $past(pbn_r)))
    else $error("erased block not taken as free block");

  a_accept_starts_split: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_SPLIT && busy))
    else $error("accepted transaction not started");

endmodule
